// ===== rtl/uart_transceiver_fifo_core_assert.svh =====
// ----------------------------------------------------------------------------
// uart_transceiver_fifo_core assertion macros
// Shared concurrent assertion forms for the USART core checkers.
// ----------------------------------------------------------------------------
`ifndef UART_TRANSCEIVER_FIFO_CORE_ASSERT_SVH
`define UART_TRANSCEIVER_FIFO_CORE_ASSERT_SVH

// property holds at every clock edge outside reset
`define UTF_ASSERT_NOW(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("utf assertion failed");

// consequence holds in the cycle after the antecedent
`define UTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("utf assertion failed");

`endif

// ===== rtl/utf_pkg.sv =====
// ----------------------------------------------------------------------------
// utf_pkg
// Shared types, codes and framing functions of the USART FIFO core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utf_pkg;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_POP  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CLK_ASYNC = 2'd0,
    CLK_EMIT  = 2'd1,
    CLK_RECV  = 2'd2
  } clk_mode_e;

  typedef enum logic [1:0] {
    PAR_NONE = 2'd0,
    PAR_EVEN = 2'd1,
    PAR_ODD  = 2'd2
  } parity_e;

  typedef enum logic [2:0] {
    REG_BIT_DELAY   = 3'd0,
    REG_DATA_BITS   = 3'd1,
    REG_PARITY_MODE = 3'd2,
    REG_STOP_BITS   = 3'd3,
    REG_CLOCK_MODE  = 3'd4,
    REG_DIR_ENABLE  = 3'd5,
    REG_RX_ENABLE   = 3'd6
  } reg_idx_e;

  localparam int unsigned E_OVR_BIT = 9;

  typedef struct packed {
    logic [15:0] bit_delay;
    logic [3:0]  data_bits;
    logic [1:0]  parity_mode;
    logic [1:0]  stop_bits;
    logic [1:0]  clock_mode;
    logic        dir_enable;
    logic        rx_enable;
  } cfg_t;

  typedef struct packed {
    logic step;
    logic tick;
    logic push;
    logic pop;
    logic rise;
    logic fall;
  } ctl_t;

  typedef struct packed {
    logic txd;
    logic dir;
    logic busy;
    logic done;
  } tx_res_t;

  typedef struct packed {
    logic [8:0] data;
    logic       avail;
    logic       ferr;
    logic       perr;
    logic       ovr;
    logic       busy;
    logic       done;
  } rx_res_t;

  typedef struct packed {
    logic [15:0] sh;
    logic [4:0]  bits;
  } frame_t;

  function automatic logic [4:0] frame_size(cfg_t c);
    return 5'd1 + {1'b0, c.data_bits} + ((c.parity_mode != PAR_NONE) ? 5'd1 : 5'd0)
           + {3'd0, c.stop_bits};
  endfunction

  function automatic logic [8:0] data_mask(cfg_t c);
    logic [9:0] m;
    m = (10'd1 << c.data_bits) - 10'd1;
    return m[8:0];
  endfunction

  function automatic logic parity(cfg_t c, logic [8:0] d);
    return (^(d & data_mask(c))) ^ (c.parity_mode == PAR_ODD);
  endfunction

  function automatic frame_t load_frame(cfg_t c, logic [8:0] data);
    frame_t     r;
    logic [8:0] d;
    logic [15:0] f;
    d = data & data_mask(c);
    f = (c.stop_bits == 2'd2) ? 16'd3 : 16'd1;
    if (c.parity_mode != PAR_NONE) f = {f[14:0], parity(c, d)};
    f = (f << c.data_bits) | {7'd0, d};
    f = {f[14:0], 1'b0};
    r.bits = frame_size(c) + 5'd1;
    if (c.dir_enable) begin
      f = {f[14:0], 1'b1};
      r.bits = r.bits + 5'd1;
    end
    r.sh = f;
    return r;
  endfunction

  // bits 0..8 data, 9 overrun, 10 frame error, 11 parity error
  function automatic logic [11:0] rx_entry(cfg_t c, logic [15:0] sh);
    logic [15:0] f;
    logic [8:0]  e;
    logic        perr;
    logic        ferr;
    f = sh >> (5'd16 - frame_size(c));
    f = f >> 1;
    e = f[8:0] & data_mask(c);
    f = f >> c.data_bits;
    perr = 1'b0;
    if (c.parity_mode != PAR_NONE) begin
      perr = f[0] != parity(c, e);
      f = f >> 1;
    end
    ferr = !f[0] || ((c.stop_bits == 2'd2) && !f[1]);
    return {perr, ferr, 1'b0, e};
  endfunction

endpackage

// ===== rtl/utf_tx.sv =====
// ----------------------------------------------------------------------------
// utf_tx
// Transmit FIFO, frame shifter and bit timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf_tx #(
  parameter int unsigned TX_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  utf_pkg::ctl_t     ctl_i,
  input  logic [8:0]        tx_data_i,
  input  utf_pkg::cfg_t     cfg_i,
  output utf_pkg::tx_res_t  res_o
);

  localparam int unsigned CW = $clog2(TX_DEPTH + 1);
  localparam int unsigned IW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TX_DEPTH);
  localparam logic [CW-1:0] LAST_C  = CW'(TX_DEPTH - 1);

  typedef struct packed {
    logic [15:0]   sh;
    logic [4:0]    bits;
    logic          txd;
    logic          dir;
    logic          done;
    logic [CW-1:0] cnt;
    logic [1:0]    pops;
  } st_t;

  logic [8:0]    q_q [TX_DEPTH];
  logic [8:0]    q_d [TX_DEPTH];
  logic [8:0]    qx  [TX_DEPTH+2];
  logic [15:0]   sh_q;
  logic [4:0]    bits_q;
  logic          txd_q;
  logic          dir_q;
  logic [CW-1:0] cnt_q;
  logic [15:0]   tmr_q, tmr_d;
  st_t           s;

  function automatic st_t shift_one(st_t st, logic [8:0] nf, utf_pkg::cfg_t c);
    st_t             r;
    utf_pkg::frame_t f;
    r = st;
    if (r.bits != 5'd0) begin
      if (r.bits == 5'd1) begin
        r.done = 1'b1;
        if (r.cnt != '0) begin
          r.cnt  = r.cnt - 1'b1;
          r.pops = r.pops + 2'd1;
        end
        if (r.cnt != '0) begin
          f      = utf_pkg::load_frame(c, nf);
          r.sh   = f.sh;
          r.bits = f.bits;
        end else if (c.dir_enable) begin
          r.dir = 1'b0;
        end
      end
      if (r.bits > 5'd1) begin
        r.txd = r.sh[0];
        r.sh  = {1'b0, r.sh[15:1]};
      end
      r.bits = r.bits - 5'd1;
    end
    return r;
  endfunction

  always_comb begin
    utf_pkg::frame_t f;
    logic [CW-1:0]   c;
    for (int i = 0; i < TX_DEPTH; i++) qx[i] = q_q[i];
    qx[TX_DEPTH]   = '0;
    qx[TX_DEPTH+1] = '0;
    q_d   = q_q;
    tmr_d = tmr_q;
    s     = '{sh: sh_q, bits: bits_q, txd: txd_q, dir: dir_q, done: 1'b0,
              cnt: cnt_q, pops: 2'd0};
    f     = '0;
    c     = '0;
    if (ctl_i.push) begin
      c = (cnt_q >= DEPTH_C) ? LAST_C : cnt_q;
      q_d[c[IW-1:0]] = tx_data_i;
      s.cnt = c + 1'b1;
      if (bits_q == 5'd0) begin
        f      = utf_pkg::load_frame(cfg_i, q_d[0]);
        s.sh   = f.sh;
        s.bits = f.bits;
        if (cfg_i.dir_enable) s.dir = 1'b1;
        if (cfg_i.clock_mode == utf_pkg::CLK_ASYNC) begin
          s     = shift_one(s, qx[1], cfg_i);
          tmr_d = cfg_i.bit_delay;
        end
      end
    end
    if (ctl_i.tick) begin
      if (tmr_q != 16'd0) begin
        tmr_d = tmr_q - 16'd1;
        if (tmr_d == 16'd0) begin
          s = shift_one(s, (s.pops == 2'd0) ? qx[1] : qx[2], cfg_i);
          if (s.bits != 5'd0) tmr_d = cfg_i.bit_delay;
        end
      end
      if (ctl_i.rise && (s.bits != 5'd0)) begin
        s = shift_one(s, (s.pops == 2'd0) ? qx[1] : qx[2], cfg_i);
      end
      for (int i = 0; i < TX_DEPTH; i++) begin
        case (s.pops)
          2'd1:    q_d[i] = qx[i+1];
          2'd2:    q_d[i] = qx[i+2];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q   <= '0;
      bits_q <= '0;
      txd_q  <= 1'b1;
      dir_q  <= 1'b0;
      cnt_q  <= '0;
      tmr_q  <= '0;
    end else if (ctl_i.step) begin
      sh_q   <= s.sh;
      bits_q <= s.bits;
      txd_q  <= s.txd;
      dir_q  <= s.dir;
      cnt_q  <= s.cnt;
      tmr_q  <= tmr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step) q_q <= q_d;
  end

  assign res_o = '{txd: s.txd, dir: s.dir, busy: (s.bits != 5'd0), done: s.done};

endmodule

// ===== rtl/utf_rx.sv =====
// ----------------------------------------------------------------------------
// utf_rx
// Receive sampler, frame checker and receive FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf_rx #(
  parameter int unsigned RX_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  utf_pkg::ctl_t     ctl_i,
  input  logic              rxd_i,
  input  utf_pkg::cfg_t     cfg_i,
  input  logic              clear_i,
  output utf_pkg::rx_res_t  res_o
);

  localparam int unsigned CW = $clog2(RX_DEPTH + 1);
  localparam int unsigned IW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(RX_DEPTH);
  localparam logic [CW-1:0] LAST_C  = CW'(RX_DEPTH - 1);

  typedef struct packed {
    logic [15:0]   sh;
    logic [3:0]    bits;
    logic [16:0]   tmr;
    logic [CW-1:0] cnt;
    logic [IW-1:0] widx;
    logic          push;
    logic          ovr;
    logic          done;
    logic [11:0]   e;
  } st_t;

  logic [11:0]   q_q [RX_DEPTH];
  logic [11:0]   q_d [RX_DEPTH];
  logic [11:0]   qx  [RX_DEPTH+1];
  logic [15:0]   sh_q;
  logic [3:0]    bits_q;
  logic [16:0]   tmr_q;
  logic [CW-1:0] cnt_q;
  logic          lrxd_q, lrxd_d;
  logic [4:0]    fsz;
  st_t           s;

  function automatic st_t shift_one(st_t st, logic lv, utf_pkg::cfg_t c);
    st_t r;
    r = st;
    if (r.bits != 4'd0) begin
      if (r.bits > 4'd1) r.sh = {lv, r.sh[15:1]};
      r.bits = r.bits - 4'd1;
      if (r.bits == 4'd0) begin
        r.e = utf_pkg::rx_entry(c, r.sh);
        if (r.cnt >= DEPTH_C) r.cnt = LAST_C;
        r.widx = r.cnt[IW-1:0];
        r.cnt  = r.cnt + 1'b1;
        r.push = 1'b1;
        r.done = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic st_t start_one(st_t st, logic [3:0] fs, utf_pkg::cfg_t c);
    st_t r;
    r = st;
    r.sh   = '0;
    r.bits = fs;
    if (r.cnt >= DEPTH_C) begin
      r.cnt = LAST_C;
      if (r.cnt != '0) r.ovr = 1'b1;
    end
    if (c.clock_mode == utf_pkg::CLK_ASYNC) begin
      r.tmr = {1'b0, c.bit_delay} + {2'b0, c.bit_delay[15:1]};
    end
    return r;
  endfunction

  assign fsz = utf_pkg::frame_size(cfg_i);

  always_comb begin
    for (int i = 0; i < RX_DEPTH; i++) qx[i] = q_q[i];
    qx[RX_DEPTH] = '0;
    q_d    = q_q;
    lrxd_d = lrxd_q;
    s      = '{sh: sh_q, bits: bits_q, tmr: tmr_q, cnt: cnt_q, widx: '0,
               push: 1'b0, ovr: 1'b0, done: 1'b0, e: '0};
    if (ctl_i.tick) begin
      lrxd_d = rxd_i;
      if (s.tmr != 17'd0) begin
        s.tmr = s.tmr - 17'd1;
        if ((s.tmr == 17'd0) && (s.bits != 4'd0)) begin
          s = shift_one(s, rxd_i, cfg_i);
          if (s.bits == 4'd1) s.tmr = {2'b0, cfg_i.bit_delay[15:1]};
          else if (s.bits != 4'd0) s.tmr = {1'b0, cfg_i.bit_delay};
        end
      end
      if (ctl_i.fall) begin
        if (s.bits != 4'd0) s = shift_one(s, rxd_i, cfg_i);
        else if (cfg_i.rx_enable && !rxd_i) s = start_one(s, fsz[3:0], cfg_i);
      end
      if ((cfg_i.clock_mode == utf_pkg::CLK_ASYNC) && cfg_i.rx_enable &&
          (s.bits == 4'd0) && lrxd_q && !rxd_i) begin
        s = start_one(s, fsz[3:0], cfg_i);
      end
      if (s.push) q_d[s.widx] = s.e;
      if (s.ovr) q_d[0][utf_pkg::E_OVR_BIT] = 1'b1;
    end
    if (ctl_i.pop && (cnt_q != '0)) begin
      s.cnt = cnt_q - 1'b1;
      for (int i = 0; i < RX_DEPTH; i++) q_d[i] = qx[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q   <= '0;
      bits_q <= '0;
      tmr_q  <= '0;
      cnt_q  <= '0;
      lrxd_q <= 1'b0;
    end else if (clear_i) begin
      bits_q <= '0;
      tmr_q  <= '0;
      cnt_q  <= '0;
    end else if (ctl_i.step) begin
      sh_q   <= s.sh;
      bits_q <= s.bits;
      tmr_q  <= s.tmr;
      cnt_q  <= s.cnt;
      lrxd_q <= lrxd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step) q_q <= q_d;
  end

  always_comb begin
    logic [11:0] front;
    front = (s.cnt != '0) ? q_d[0] : 12'd0;
    res_o = '{data: front[8:0], avail: (s.cnt != '0), ferr: front[10], perr: front[11],
              ovr: front[9], busy: (s.bits != 4'd0), done: s.done};
  end

endmodule

// ===== rtl/uart_transceiver_fifo_core.sv =====
// ----------------------------------------------------------------------------
// uart_transceiver_fifo_core
// USART with TX/RX FIFOs, async and synchronous XCK modes, APB registers.
// ----------------------------------------------------------------------------
// Result path: the accepted word is held in the input reg, then its result
//   word in the result reg.
// Throughput: 1 word per cycle unless out_ready_i stalls; each word (tick,
//   push, pop or no-op) takes a single pass through TX, RX and XCK logic.
// Reset: async active low; FIFOs empty, timers stopped, txd high, registers
//   at defaults (bit_delay 2, 8 data bits, no parity, 1 stop, async, off).
`timescale 1ns / 1ps

module uart_transceiver_fifo_core #(
  parameter int unsigned TX_DEPTH = 8,
  parameter int unsigned RX_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [8:0]  tx_data_i,
  input  logic        rxd_i,
  input  logic        xck_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        txd_o,
  output logic        dir_o,
  output logic        xck_out_o,
  output logic [8:0]  rx_data_o,
  output logic        rx_nonempty_o,
  output logic        frame_error_o,
  output logic        parity_error_o,
  output logic        overrun_o,
  output logic        tx_busy_o,
  output logic        rx_busy_o,
  output logic        tx_done_o,
  output logic        rx_done_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              s1_v_q;
  utf_pkg::cmd_e     cmd_q;
  logic [8:0]        tx_data_q;
  logic              rxd_q;
  logic              xck_in_q;
  logic              adv;
  utf_pkg::cfg_t     cfg_q;
  utf_pkg::ctl_t     ctl;
  utf_pkg::reg_idx_e ridx;
  logic              wr;
  logic              rx_clear;
  logic              xck_q, xck_d;
  logic [15:0]       half_q, half_d;
  logic              rise, fall;
  utf_pkg::tx_res_t  tx_res, tx_res_q;
  utf_pkg::rx_res_t  rx_res, rx_res_q;
  logic              out_v_q;
  logic              xck_out_q;

  assign adv        = s1_v_q & (~out_v_q | out_ready_i);
  assign in_ready_o = ~s1_v_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_v_q <= 1'b1;
    end else if (adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q     <= utf_pkg::cmd_e'(cmd_i);
      tx_data_q <= tx_data_i;
      rxd_q     <= rxd_i;
      xck_in_q  <= xck_in_i;
    end
  end

  always_comb begin
    ctl      = '0;
    ctl.step = adv;
    ctl.tick = adv && (cmd_q == utf_pkg::CMD_TICK);
    ctl.push = adv && (cmd_q == utf_pkg::CMD_PUSH);
    ctl.pop  = adv && (cmd_q == utf_pkg::CMD_POP);
    ctl.rise = rise;
    ctl.fall = fall;
  end

  // XCK generator / follower
  always_comb begin
    xck_d  = xck_q;
    half_d = half_q;
    rise   = 1'b0;
    fall   = 1'b0;
    if (adv && (cmd_q == utf_pkg::CMD_TICK)) begin
      if ((cfg_q.clock_mode == utf_pkg::CLK_EMIT) && (half_q != 16'd0)) begin
        half_d = half_q - 16'd1;
        if (half_d == 16'd0) begin
          xck_d  = ~xck_q;
          rise   = xck_d;
          fall   = ~xck_d;
          half_d = {1'b0, cfg_q.bit_delay[15:1]};
        end
      end
      if ((cfg_q.clock_mode == utf_pkg::CLK_RECV) && (xck_in_q != xck_q)) begin
        xck_d = xck_in_q;
        rise  = xck_in_q;
        fall  = ~xck_in_q;
      end
    end
  end

  // register port
  assign wr       = psel & penable & pwrite;
  assign ridx     = utf_pkg::reg_idx_e'(paddr[4:2]);
  assign pready   = 1'b1;
  assign rx_clear = wr && (ridx == utf_pkg::REG_RX_ENABLE) && !pwdata[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_delay   <= 16'd2;
      cfg_q.data_bits   <= 4'd8;
      cfg_q.parity_mode <= utf_pkg::PAR_NONE;
      cfg_q.stop_bits   <= 2'd1;
      cfg_q.clock_mode  <= utf_pkg::CLK_ASYNC;
      cfg_q.dir_enable  <= 1'b0;
      cfg_q.rx_enable   <= 1'b0;
      xck_q             <= 1'b0;
      half_q            <= '0;
    end else if (wr) begin
      case (ridx)
        utf_pkg::REG_BIT_DELAY: begin
          cfg_q.bit_delay <= (pwdata[15:0] < 16'd2) ? 16'd2 : pwdata[15:0];
        end
        utf_pkg::REG_DATA_BITS: begin
          if (pwdata[3:0] inside {[4'd5:4'd9]}) cfg_q.data_bits <= pwdata[3:0];
        end
        utf_pkg::REG_PARITY_MODE: begin
          if (pwdata[1:0] != 2'd3) cfg_q.parity_mode <= pwdata[1:0];
        end
        utf_pkg::REG_STOP_BITS: begin
          if (pwdata[1:0] inside {2'd1, 2'd2}) cfg_q.stop_bits <= pwdata[1:0];
        end
        utf_pkg::REG_CLOCK_MODE: begin
          if (pwdata[1:0] != 2'd3) begin
            cfg_q.clock_mode <= pwdata[1:0];
            xck_q            <= 1'b0;
            half_q           <= (pwdata[1:0] == utf_pkg::CLK_EMIT) ?
                                {1'b0, cfg_q.bit_delay[15:1]} : 16'd0;
          end
        end
        utf_pkg::REG_DIR_ENABLE: cfg_q.dir_enable <= pwdata[0];
        utf_pkg::REG_RX_ENABLE:  cfg_q.rx_enable  <= pwdata[0];
        default: ;
      endcase
    end else if (adv) begin
      xck_q  <= xck_d;
      half_q <= half_d;
    end
  end

  always_comb begin
    case (ridx)
      utf_pkg::REG_BIT_DELAY:   prdata = {16'd0, cfg_q.bit_delay};
      utf_pkg::REG_DATA_BITS:   prdata = {28'd0, cfg_q.data_bits};
      utf_pkg::REG_PARITY_MODE: prdata = {30'd0, cfg_q.parity_mode};
      utf_pkg::REG_STOP_BITS:   prdata = {30'd0, cfg_q.stop_bits};
      utf_pkg::REG_CLOCK_MODE:  prdata = {30'd0, cfg_q.clock_mode};
      utf_pkg::REG_DIR_ENABLE:  prdata = {31'd0, cfg_q.dir_enable};
      utf_pkg::REG_RX_ENABLE:   prdata = {31'd0, cfg_q.rx_enable};
      default:                  prdata = 32'd0;
    endcase
  end

  utf_tx #(.TX_DEPTH(TX_DEPTH)) u_tx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .tx_data_i (tx_data_q),
    .cfg_i     (cfg_q),
    .res_o     (tx_res)
  );

  utf_rx #(.RX_DEPTH(RX_DEPTH)) u_rx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .rxd_i   (rxd_q),
    .cfg_i   (cfg_q),
    .clear_i (rx_clear),
    .res_o   (rx_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx_res_q  <= tx_res;
      rx_res_q  <= rx_res;
      xck_out_q <= (cfg_q.clock_mode == utf_pkg::CLK_EMIT) && xck_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign txd_o          = tx_res_q.txd;
  assign dir_o          = tx_res_q.dir;
  assign xck_out_o      = xck_out_q;
  assign rx_data_o      = rx_res_q.data;
  assign rx_nonempty_o  = rx_res_q.avail;
  assign frame_error_o  = rx_res_q.ferr;
  assign parity_error_o = rx_res_q.perr;
  assign overrun_o      = rx_res_q.ovr;
  assign tx_busy_o      = tx_res_q.busy;
  assign rx_busy_o      = rx_res_q.busy;
  assign tx_done_o      = tx_res_q.done;
  assign rx_done_o      = rx_res_q.done;

endmodule

// ===== rtl/utf_chk.sv =====
// ----------------------------------------------------------------------------
// utf_chk
// Port-level checks on the USART FIFO core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uart_transceiver_fifo_core_assert.svh"

module utf_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       pready,
  input logic       txd_o,
  input logic [8:0] rx_data_o,
  input logic       rx_nonempty_o,
  input logic       frame_error_o,
  input logic       parity_error_o,
  input logic       overrun_o
);

  logic front_clear;

  assign front_clear = (rx_data_o == 9'd0) && !frame_error_o && !parity_error_o && !overrun_o;

  `UTF_ASSERT_NOW(a_pready_high, clk_i, rst_ni, pready)
  `UTF_ASSERT_NOW(a_empty_front_zero, clk_i, rst_ni, !(out_valid_o && !rx_nonempty_o) || front_clear)
  `UTF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `UTF_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(txd_o) && $stable(rx_data_o))

endmodule

bind uart_transceiver_fifo_core utf_chk u_chk (.*);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the USART FIFO core: a directed table, a TX queue
// overfill, out-of-range register writes, then random ticks, pushes, pops and
// no-ops, rxd mostly looped back from the predicted txd, over several framing
// and clock settings, checked word by word against a behavioral predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic       txd;
    logic       dir;
    logic       xck;
    logic [8:0] data;
    logic       avail;
    logic       ferr;
    logic       perr;
    logic       ovr;
    logic       tbusy;
    logic       rbusy;
    logic       tdone;
    logic       rdone;
  } line_t;

  typedef struct {
    utf_pkg::cmd_e cmd;
    logic [8:0]    data;
    logic          rxd;
    logic          xck;
    bit            typed;
    line_t         want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  cmd = utf_pkg::CMD_TICK;
  logic [8:0]  tx_data = '0;
  logic        rxd = 1'b1;
  logic        xck_in = 1'b0;
  logic        out_ready = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        in_ready, out_valid;
  logic        txd, dir, xck_out, rx_avail, ferr, perr, ovr, tbusy, rbusy, tdone, rdone;
  logic [8:0]  rx_data;
  logic [31:0] prdata;
  logic        pready;

  uart_transceiver_fifo_core DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .tx_data_i(tx_data), .rxd_i(rxd), .xck_in_i(xck_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .txd_o(txd), .dir_o(dir), .xck_out_o(xck_out), .rx_data_o(rx_data),
    .rx_nonempty_o(rx_avail), .frame_error_o(ferr), .parity_error_o(perr),
    .overrun_o(ovr), .tx_busy_o(tbusy), .rx_busy_o(rbusy),
    .tx_done_o(tdone), .rx_done_o(rdone),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0]        c_delay;
  int unsigned        c_bits, c_stop;
  utf_pkg::parity_e   c_par;
  utf_pkg::clk_mode_e c_mode;
  logic               c_dir, c_rxen;
  logic [8:0]         txq[8];
  logic [11:0]        rxq[8];
  int unsigned        tx_cnt, rx_cnt, tx_left, rx_left, tx_tmr, rx_tmr, xck_tmr;
  logic [15:0]        tx_sh, rx_sh;
  logic               ln_txd, ln_dir, ln_xck, ln_rxd, tx_pulse, rx_pulse;

  line_t       line_q[$];
  int          errors = 0;
  int          n_items = 0;
  int          idle_in = 22, idle_out = 53;
  int          hold_cnt = 0;
  int          p_push = 10, p_pop = 10;
  logic        xck_drv = 1'b0;

  function automatic int unsigned fsize();
    return 1 + c_bits + ((c_par != utf_pkg::PAR_NONE) ? 1 : 0) + c_stop;
  endfunction

  function automatic logic [8:0] dmask();
    return 9'h1FF >> (9 - c_bits);
  endfunction

  function automatic logic par_of(logic [8:0] d);
    return (^(d & dmask())) ^ (c_par == utf_pkg::PAR_ODD);
  endfunction

  function automatic void load_tx();
    logic [31:0] f;
    logic [8:0]  d;
    d = txq[0] & dmask();
    f = (c_stop == 2) ? 32'd3 : 32'd1;
    if (c_par != utf_pkg::PAR_NONE) f = (f << 1) | par_of(d);
    f = ((f << c_bits) | d) << 1;
    tx_left = fsize() + 1;
    if (c_dir) begin
      f = (f << 1) | 32'd1;
      tx_left++;
    end
    tx_sh = f[15:0];
  endfunction

  function automatic void tx_shift();
    if (tx_left == 0) return;
    if (tx_left == 1) begin
      tx_pulse = 1'b1;
      if (tx_cnt != 0) begin
        for (int i = 0; i < 7; i++) txq[i] = txq[i+1];
        tx_cnt--;
      end
      if (tx_cnt != 0) load_tx();
      else if (c_dir) ln_dir = 1'b0;
    end
    if (tx_left > 1) begin
      ln_txd = tx_sh[0];
      tx_sh = tx_sh >> 1;
    end
    tx_left--;
  endfunction

  function automatic void rx_shift();
    logic [15:0] f;
    logic [8:0]  e;
    logic        pe, fe;
    if (rx_left == 0) return;
    if (rx_left > 1) rx_sh = {ln_rxd, rx_sh[15:1]};
    rx_left--;
    if (rx_left == 0) begin
      f = rx_sh >> (16 - fsize());
      f = f >> 1;
      e = f[8:0] & dmask();
      f = f >> c_bits;
      pe = 1'b0;
      if (c_par != utf_pkg::PAR_NONE) begin
        pe = f[0] != par_of(e);
        f = f >> 1;
      end
      fe = !f[0] || (c_stop == 2 && !f[1]);
      if (rx_cnt >= 8) rx_cnt = 7;
      rxq[rx_cnt] = {pe, fe, 1'b0, e};
      rx_cnt++;
      rx_pulse = 1'b1;
    end
  endfunction

  function automatic void rx_start();
    rx_sh = '0;
    rx_left = fsize();
    if (rx_cnt >= 8) begin
      rx_cnt = 7;
      if (rx_cnt != 0) rxq[0][utf_pkg::E_OVR_BIT] = 1'b1;
    end
    if (c_mode == utf_pkg::CLK_ASYNC) rx_tmr = c_delay + c_delay / 2;
  endfunction

  function automatic void clk_edge(logic rising);
    if (rising) begin
      if (tx_left != 0) tx_shift();
    end else if (rx_left != 0) begin
      rx_shift();
    end else if (c_rxen && !ln_rxd) begin
      rx_start();
    end
  endfunction

  function automatic void model_reset();
    c_delay = 16'd2; c_bits = 8; c_par = utf_pkg::PAR_NONE; c_stop = 1;
    c_mode = utf_pkg::CLK_ASYNC; c_dir = 1'b0; c_rxen = 1'b0;
    tx_cnt = 0; rx_cnt = 0; tx_left = 0; rx_left = 0;
    tx_tmr = 0; rx_tmr = 0; xck_tmr = 0; tx_sh = '0; rx_sh = '0;
    ln_txd = 1'b1; ln_dir = 1'b0; ln_xck = 1'b0; ln_rxd = 1'b0;
  endfunction

  function automatic void model_cfg(utf_pkg::reg_idx_e r, logic [31:0] v);
    case (r)
      utf_pkg::REG_BIT_DELAY: c_delay = (v[15:0] < 2) ? 16'd2 : v[15:0];
      utf_pkg::REG_DATA_BITS: if (v[3:0] >= 5 && v[3:0] <= 9) c_bits = v[3:0];
      utf_pkg::REG_PARITY_MODE: if (v[1:0] != 2'd3) c_par = utf_pkg::parity_e'(v[1:0]);
      utf_pkg::REG_STOP_BITS: if (v[1:0] == 2'd1 || v[1:0] == 2'd2) c_stop = v[1:0];
      utf_pkg::REG_CLOCK_MODE: if (v[1:0] != 2'd3) begin
        c_mode = utf_pkg::clk_mode_e'(v[1:0]);
        ln_xck = 1'b0;
        xck_tmr = (c_mode == utf_pkg::CLK_EMIT) ? c_delay / 2 : 0;
      end
      utf_pkg::REG_DIR_ENABLE: c_dir = v[0];
      utf_pkg::REG_RX_ENABLE: begin
        c_rxen = v[0];
        if (!c_rxen) begin
          rx_left = 0; rx_tmr = 0; rx_cnt = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] model_reg(utf_pkg::reg_idx_e r);
    case (r)
      utf_pkg::REG_BIT_DELAY:   return {16'd0, c_delay};
      utf_pkg::REG_DATA_BITS:   return c_bits;
      utf_pkg::REG_PARITY_MODE: return {30'd0, c_par};
      utf_pkg::REG_STOP_BITS:   return c_stop;
      utf_pkg::REG_CLOCK_MODE:  return {30'd0, c_mode};
      utf_pkg::REG_DIR_ENABLE:  return {31'd0, c_dir};
      utf_pkg::REG_RX_ENABLE:   return {31'd0, c_rxen};
      default:                  return 32'd0;
    endcase
  endfunction

  function automatic line_t usart_step(logic [1:0] c, logic [8:0] d, logic rx, logic xin);
    line_t       o;
    logic        old;
    logic [11:0] front;
    tx_pulse = 1'b0;
    rx_pulse = 1'b0;
    case (c)
      utf_pkg::CMD_TICK: begin
        old = ln_rxd;
        ln_rxd = rx;
        if (tx_tmr != 0) begin
          tx_tmr--;
          if (tx_tmr == 0) begin
            tx_shift();
            if (tx_left != 0) tx_tmr = c_delay;
          end
        end
        if (rx_tmr != 0) begin
          rx_tmr--;
          if (rx_tmr == 0 && rx_left != 0) begin
            rx_shift();
            if (rx_left == 1) rx_tmr = c_delay / 2;
            else if (rx_left != 0) rx_tmr = c_delay;
          end
        end
        if (c_mode == utf_pkg::CLK_EMIT && xck_tmr != 0) begin
          xck_tmr--;
          if (xck_tmr == 0) begin
            ln_xck = !ln_xck;
            clk_edge(ln_xck);
            xck_tmr = c_delay / 2;
          end
        end
        if (c_mode == utf_pkg::CLK_RECV && xin != ln_xck) begin
          ln_xck = xin;
          clk_edge(xin);
        end
        if (c_mode == utf_pkg::CLK_ASYNC && c_rxen && rx_left == 0 && old && !rx) rx_start();
      end
      utf_pkg::CMD_PUSH: begin
        if (tx_cnt >= 8) tx_cnt = 7;
        txq[tx_cnt] = d;
        tx_cnt++;
        if (tx_left == 0) begin
          load_tx();
          if (c_dir) ln_dir = 1'b1;
          if (c_mode == utf_pkg::CLK_ASYNC) begin
            tx_shift();
            tx_tmr = c_delay;
          end
        end
      end
      utf_pkg::CMD_POP: if (rx_cnt != 0) begin
        for (int i = 0; i < 7; i++) rxq[i] = rxq[i+1];
        rx_cnt--;
      end
      default: ;
    endcase
    front = (rx_cnt != 0) ? rxq[0] : 12'd0;
    o.txd = ln_txd;
    o.dir = ln_dir;
    o.xck = (c_mode == utf_pkg::CLK_EMIT) && ln_xck;
    o.data = front[8:0];
    o.avail = rx_cnt != 0;
    o.ferr = front[10];
    o.perr = front[11];
    o.ovr = front[9];
    o.tbusy = tx_left != 0;
    o.rbusy = rx_left != 0;
    o.tdone = tx_pulse;
    o.rdone = rx_pulse;
    return o;
  endfunction

  task automatic report(string fld, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", fld, got, want, $realtime);
    errors++;
  endtask

  task automatic check_line(line_t g);
    line_t w;
    if (line_q.size() == 0) begin
      report("unexpected word", 1, 0);
      return;
    end
    w = line_q[0];
    line_q.delete(0);
    if (g.txd !== w.txd) report("txd", g.txd, w.txd);
    if (g.dir !== w.dir) report("dir", g.dir, w.dir);
    if (g.xck !== w.xck) report("xck_out", g.xck, w.xck);
    if (g.data !== w.data) report("rx_data", g.data, w.data);
    if (g.avail !== w.avail) report("rx_nonempty", g.avail, w.avail);
    if (g.ferr !== w.ferr) report("frame_error", g.ferr, w.ferr);
    if (g.perr !== w.perr) report("parity_error", g.perr, w.perr);
    if (g.ovr !== w.ovr) report("overrun", g.ovr, w.ovr);
    if (g.tbusy !== w.tbusy) report("tx_busy", g.tbusy, w.tbusy);
    if (g.rbusy !== w.rbusy) report("rx_busy", g.rbusy, w.rbusy);
    if (g.tdone !== w.tdone) report("tx_done", g.tdone, w.tdone);
    if (g.rdone !== w.rdone) report("rx_done", g.rdone, w.rdone);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready)
      check_line({txd, dir, xck_out, rx_data, rx_avail, ferr, perr, ovr,
                  tbusy, rbusy, tdone, rdone});
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_out);
      end
    end
  end

  task automatic send_word(logic [1:0] c, logic [8:0] d, logic rx, logic xin,
                           bit typed, line_t want);
    line_t p;
    if (n_items < 650) begin
      idle_in = 22; idle_out = 53;
    end else if (n_items < 1300) begin
      idle_in = 53; idle_out = 22;
    end else begin
      idle_in = 0; idle_out = 0;
    end
    @(negedge clk_i);
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    cmd <= c;
    tx_data <= d;
    rxd <= rx;
    xck_in <= xin;
    do @(posedge clk_i); while (!in_ready);
    p = usart_step(c, d, rx, xin);
    line_q.insert(line_q.size(), typed ? want : p);
    n_items++;
  endtask

  task automatic send_random();
    int         r;
    logic [1:0] c;
    logic       rx;
    r = $urandom_range(99);
    if (r < p_push) c = utf_pkg::CMD_PUSH;
    else if (r < p_push + p_pop) c = utf_pkg::CMD_POP;
    else if (r < p_push + p_pop + 2) c = utf_pkg::CMD_NOP;
    else c = utf_pkg::CMD_TICK;
    rx = ($urandom_range(99) < 6) ? 1'($urandom_range(1)) : ln_txd;
    if (c_mode == utf_pkg::CLK_RECV) begin
      if ($urandom_range(99) < 40) xck_drv = !xck_drv;
    end else begin
      xck_drv = 1'($urandom_range(1));
    end
    send_word(c, 9'($urandom_range(511)), rx, xck_drv, 1'b0, '0);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (line_q.size() == 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic cfg_write(utf_pkg::reg_idx_e r, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    model_cfg(r, v);
    if (pready !== 1'b1) report("pready", pready, 1);
    if (prdata !== model_reg(r)) report("prdata", prdata, model_reg(r));
  endtask

  task automatic set_framing(int bd, int db, utf_pkg::parity_e pm, int sb,
                             utf_pkg::clk_mode_e cm, bit de, bit re);
    cfg_write(utf_pkg::REG_BIT_DELAY, bd);
    cfg_write(utf_pkg::REG_DATA_BITS, db);
    cfg_write(utf_pkg::REG_PARITY_MODE, {30'd0, pm});
    cfg_write(utf_pkg::REG_STOP_BITS, sb);
    cfg_write(utf_pkg::REG_CLOCK_MODE, {30'd0, cm});
    cfg_write(utf_pkg::REG_DIR_ENABLE, {31'd0, de});
    cfg_write(utf_pkg::REG_RX_ENABLE, {31'd0, re});
  endtask

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    row_t       rows[$];
    line_t      idle_line;
    int         n;
    logic [8:0] fill[9];
    fill = '{9'h000, 9'h155, 9'h0AA, 9'h100, 9'h001, 9'h1FF, 9'h0F0, 9'h00F, 9'h123};
    model_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    idle_line = '0;
    idle_line.txd = 1'b1;
    rows.insert(rows.size(), row_t'{utf_pkg::CMD_TICK, 9'h000, 1'b1, 1'b0, 1'b1, idle_line});
    rows.insert(rows.size(), row_t'{utf_pkg::CMD_POP, 9'h1FF, 1'b1, 1'b1, 1'b1, idle_line});
    rows.insert(rows.size(), row_t'{utf_pkg::CMD_NOP, 9'h000, 1'b0, 1'b0, 1'b1, idle_line});
    rows.insert(rows.size(), row_t'{utf_pkg::CMD_TICK, 9'h1FF, 1'b0, 1'b1, 1'b1, idle_line});
    rows.insert(rows.size(), row_t'{utf_pkg::CMD_PUSH, 9'h1FF, 1'b1, 1'b0, 1'b1,
                                    line_t'{txd: 1'b0, tbusy: 1'b1, default: '0}});
    foreach (rows[i])
      send_word(rows[i].cmd, rows[i].data, rows[i].rxd, rows[i].xck,
                rows[i].typed, rows[i].want);
    rows.delete();
    // fill the TX queue past its depth, newest entry gets replaced
    foreach (fill[i])
      send_word(utf_pkg::CMD_PUSH, fill[i], 1'b1, 1'b0, 1'b0, '0);
    repeat (6) send_word(utf_pkg::CMD_TICK, 9'h0, 1'b0, 1'b1, 1'b0, '0);
    drain();

    // out-of-range register values
    cfg_write(utf_pkg::REG_BIT_DELAY, 0);
    cfg_write(utf_pkg::REG_DATA_BITS, 4);
    cfg_write(utf_pkg::REG_DATA_BITS, 10);
    cfg_write(utf_pkg::REG_PARITY_MODE, 3);
    cfg_write(utf_pkg::REG_STOP_BITS, 0);
    cfg_write(utf_pkg::REG_STOP_BITS, 3);
    cfg_write(utf_pkg::REG_CLOCK_MODE, 3);
    cfg_write(utf_pkg::REG_RX_ENABLE, 1);
    repeat (4) send_random();
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: set_framing(2, 5, utf_pkg::PAR_NONE, 1, utf_pkg::CLK_ASYNC, 1'b0, 1'b1);
        1: set_framing(3, 9, utf_pkg::PAR_ODD, 2, utf_pkg::CLK_ASYNC, 1'b1, 1'b1);
        2: set_framing(4, 8, utf_pkg::PAR_EVEN, 1, utf_pkg::CLK_EMIT, 1'b0, 1'b1);
        3: set_framing(4, 7, utf_pkg::PAR_NONE, 2, utf_pkg::CLK_RECV, 1'b1, 1'b1);
        4: set_framing(65535, 8, utf_pkg::PAR_EVEN, 2, utf_pkg::CLK_ASYNC, 1'b1, 1'b1);
        5: set_framing(2, 6, utf_pkg::PAR_ODD, 1, utf_pkg::CLK_ASYNC, 1'b0, 1'b0);
        default: set_framing($urandom_range(2, 5), $urandom_range(5, 9),
                             utf_pkg::parity_e'($urandom_range(2)), $urandom_range(1, 2),
                             utf_pkg::clk_mode_e'($urandom_range(2)),
                             1'($urandom_range(1)), 1'b1);
      endcase
      p_push = $urandom_range(4, 14);
      p_pop = (ph % 3 == 0) ? 1 : $urandom_range(3, 15);
      if (ph == 1) hold_cnt = 150;
      n = (ph == 4) ? 30 : 146;
      for (int k = 0; k < n; k++) begin
        if (ph == 6 && k == 70) drain();
        send_random();
      end
      drain();
    end

    drain();
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/utf_pkg.sv
rtl/utf_tx.sv
rtl/utf_rx.sv
rtl/uart_transceiver_fifo_core.sv
rtl/utf_chk.sv
dv/tb_top.sv
